// ===== rtl/core/vna_pkg.sv =====
// Shared types, codes and defaults for the vertex normal accumulator.
`timescale 1ns / 1ps

package vna_pkg;

  localparam int VERTEX_DEPTH_DEF = 1024;
  localparam int ACCUM_WIDTH_DEF  = 48;

  // field widths
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int POS_W  = 16;
  localparam int STAT_W = 2;
  localparam int NRM_W  = 16;

  // queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_ADD,
    OP_FINISH,
    OP_READ,
    OP_REPORT
  } op_kind_t;

  // classified word handed from front to back
  typedef struct packed {
    op_kind_t            kind;
    logic [STAT_W-1:0]   status;
    logic [IDX_W-1:0]    a;
    logic [IDX_W-1:0]    b;
    logic [IDX_W-1:0]    c;
    logic [3*POS_W-1:0]  pos;   // {z, y, x}
    logic [CNT_W-1:0]    n;     // effective vertex count
  } op_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_PRD,
    B_EDGE,
    B_MUL,
    B_ARD,
    B_AWR,
    B_RRD,
    B_RMAG,
    B_RSH,
    B_RSQ,
    B_RSQRT,
    B_RDIV,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/core/vna_ifs.sv =====
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps

interface vna_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                cmd;
  logic [9:0]                index_a;
  logic [9:0]                index_b;
  logic [9:0]                index_c;
  logic signed [15:0]        pos_x;
  logic signed [15:0]        pos_y;
  logic signed [15:0]        pos_z;

  modport source (output valid, cmd, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, cmd, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface vna_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [15:0]        normal_x;
  logic signed [15:0]        normal_y;
  logic signed [15:0]        normal_z;

  modport source (output valid, status, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, status, normal_x, normal_y, normal_z, output ready);
endinterface

// ===== rtl/core/vertex_normal_accumulator.sv =====
// Top level of the area-weighted vertex normal accumulator.
`timescale 1ns / 1ps

// Area-weighted vertex normals. Each command word (restart, load vertex, add triangle,
// finish, read normal) gives one result word. The front end range-checks indices against
// min(vertex_count, VERTEX_DEPTH) and queues classified words (2 deep) for the back end,
// which runs one word at a time through a position memory and an accumulator memory,
// each with one write port and one read port. Steps in the back end: add triangle takes
// 3 position reads, 6 steps of one shared 17x17 multiplier and 3 read-modify-writes;
// finish walks each vertex triple the same way, unless a triangle was added since restart;
// a read of a nonzero row runs the shift, a 31-step square root and three 17-step quotient
// loops; restart clears one accumulator row per cycle. After reset the accumulator memory
// is swept with in_ch.ready low; ready is also low during a restart sweep. cfg_wdata sets
// vertex_count; write it only while the block is idle. Results wait in an output register
// while the next word is already taken.

module vertex_normal_accumulator #(
  parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF,
  parameter int ACCUM_WIDTH  = vna_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  vna_in_if.sink                     in_ch,
  vna_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [vna_pkg::CNT_W-1:0]  cfg_wdata
);

  logic                 push, q_full, q_valid, q_pop;
  vna_pkg::op_t         push_op, q_op;
  vna_pkg::back_stat_t  bstat;

  // front: count register and classification
  vna_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .bstat     (bstat),
    .push      (push),
    .push_op   (push_op)
  );

  // decouples front from back
  vna_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_op),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_op),
    .valid (q_valid)
  );

  // back: memories, face sequencer, normalizer
  vna_back #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .ACCUM_WIDTH  (ACCUM_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .bstat   (bstat),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/core/vna_front.sv =====
// Front end: count register, range checks and command classification.
`timescale 1ns / 1ps

module vna_front #(
  parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  vna_in_if.sink                     in_ch,
  input  logic                       cfg_we,
  input  logic [vna_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic                       q_full,
  input  vna_pkg::back_stat_t        bstat,
  output logic                       push,
  output vna_pkg::op_t               push_op
);

  logic [vna_pkg::CNT_W-1:0] vcount_r;
  logic [vna_pkg::CNT_W-1:0] n_eff;
  logic                      a_ok, b_ok, c_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  assign n_eff = (int'(vcount_r) < VERTEX_DEPTH) ? vcount_r
                                                 : vna_pkg::CNT_W'(VERTEX_DEPTH);

  assign a_ok = ({1'b0, in_ch.index_a} < n_eff);
  assign b_ok = ({1'b0, in_ch.index_b} < n_eff);
  assign c_ok = ({1'b0, in_ch.index_c} < n_eff);

  // no new words while the back end sweeps the accumulators
  assign in_ch.ready = !q_full && !bstat.clearing;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    push_op        = '0;
    push_op.a      = in_ch.index_a;
    push_op.b      = in_ch.index_b;
    push_op.c      = in_ch.index_c;
    push_op.pos    = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    push_op.n      = n_eff;
    push_op.status = vna_pkg::ST_OK;
    push_op.kind   = vna_pkg::OP_REPORT;
    case (in_ch.cmd)
      vna_pkg::CMD_RESTART: begin
        push_op.kind = vna_pkg::OP_CLEAR;
      end
      vna_pkg::CMD_LOAD: begin
        if (a_ok) push_op.kind = vna_pkg::OP_LOAD;
        else      push_op.status = vna_pkg::ST_RANGE;
      end
      vna_pkg::CMD_ADD: begin
        if (a_ok && b_ok && c_ok) push_op.kind = vna_pkg::OP_ADD;
        else                      push_op.status = vna_pkg::ST_RANGE;
      end
      vna_pkg::CMD_FINISH: begin
        if (n_eff == '0) push_op.status = vna_pkg::ST_EMPTY;
        else             push_op.kind = vna_pkg::OP_FINISH;
      end
      vna_pkg::CMD_READ: begin
        if (a_ok) push_op.kind = vna_pkg::OP_READ;
        else      push_op.status = vna_pkg::ST_RANGE;
      end
      default: begin
        push_op.kind = vna_pkg::OP_REPORT;
      end
    endcase
  end

endmodule

// ===== rtl/core/vna_fifo.sv =====
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module vna_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vna_pkg::op_t  din,
  output logic          full,
  input  logic          pop,
  output vna_pkg::op_t  dout,
  output logic          valid
);

  localparam int PTR_W = $clog2(vna_pkg::QUEUE_DEPTH);

  vna_pkg::op_t     ent_r [vna_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;

  assign full  = (cnt_r == (PTR_W+1)'(vna_pkg::QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/core/vna_back.sv =====
// Back end: position and accumulator memories, face sequencer, normalizer, result register.
`timescale 1ns / 1ps

module vna_back #(
  parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF,
  parameter int ACCUM_WIDTH  = vna_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  vna_pkg::op_t         q_op,
  output logic                 q_pop,
  output vna_pkg::back_stat_t  bstat,
  vna_out_if.source            out_ch
);

  localparam int ADDR_W = $clog2(VERTEX_DEPTH);
  localparam int AWD    = ACCUM_WIDTH;
  localparam int ROW_W  = 3 * AWD;
  localparam int CNT_W  = vna_pkg::CNT_W;

  // memories
  logic [47:0]      pos_mem [VERTEX_DEPTH];
  logic [ROW_W-1:0] acc_mem [VERTEX_DEPTH];
  logic             pos_we, acc_we;
  logic [ADDR_W-1:0] pos_waddr, pos_raddr, acc_waddr, acc_raddr;
  logic [47:0]      pos_wdata, pos_rd_r;
  logic [ROW_W-1:0] acc_wdata, acc_rd_r;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd_r <= acc_mem[acc_raddr];
  end

  // control and datapath registers
  vna_pkg::back_state_t state_r, state_nxt;
  vna_pkg::op_t         op_r, op_nxt;
  logic [ADDR_W-1:0]    clr_r, clr_nxt;
  logic                 emit_r, emit_nxt;
  logic                 seen_r, seen_nxt;
  logic [CNT_W-1:0]     walk_r, walk_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [1:0]           comp_r, comp_nxt;
  logic [47:0]          p_r [3];
  logic [47:0]          p_nxt [3];
  logic signed [16:0]   e1_r [3], e2_r [3], e1_nxt [3], e2_nxt [3];
  logic signed [34:0]   cr_r [3], cr_nxt [3];
  logic [AWD-1:0]       m_r [3], m_nxt [3];
  logic [2:0]           neg_r, neg_nxt;
  logic [61:0]          rem_r, rem_nxt, rt_r, rt_nxt, bit_r, bit_nxt;
  logic [45:0]          dv_r, dv_nxt;
  logic [15:0]          q_r [3], q_nxt [3];

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [15:0]          out_n_r [3], out_n_nxt [3];

  // helpers
  logic [ADDR_W-1:0]    crn [3];
  logic                 finish_op, clr_last, big, acc_zero, walk_more, out_free;
  logic signed [16:0]   mul_a, mul_b;
  logic signed [33:0]   prod;
  logic [59:0]          sq;
  logic [61:0]          rt_try;
  logic [47:0]          dsh;
  logic [3:0]           dk;
  logic [AWD-1:0]       acc_c [3];

  function automatic logic [AWD-1:0] sat_add(input logic [AWD-1:0] acc,
                                             input logic [34:0] c);
    logic [AWD:0] s;
    s = {acc[AWD-1], acc} + {{(AWD-34){c[34]}}, c};
    if (s[AWD] != s[AWD-1]) begin
      return s[AWD] ? {1'b1, {(AWD-1){1'b0}}} : {1'b0, {(AWD-1){1'b1}}};
    end
    return s[AWD-1:0];
  endfunction

  function automatic logic signed [16:0] sx(input logic [15:0] v);
    return {v[15], v};
  endfunction

  assign finish_op = (op_r.kind == vna_pkg::OP_FINISH);
  assign crn[0] = finish_op ? ADDR_W'(walk_r) : ADDR_W'(op_r.a);
  assign crn[1] = finish_op ? ADDR_W'(walk_r + CNT_W'(1)) : ADDR_W'(op_r.b);
  assign crn[2] = finish_op ? ADDR_W'(walk_r + CNT_W'(2)) : ADDR_W'(op_r.c);

  assign clr_last  = (clr_r == ADDR_W'(VERTEX_DEPTH - 1));
  assign big       = (|m_r[0][AWD-1:30]) | (|m_r[1][AWD-1:30]) | (|m_r[2][AWD-1:30]);
  assign acc_zero  = (acc_rd_r == '0);
  assign walk_more = finish_op && ({1'b0, walk_r} + (CNT_W+1)'(5) < {1'b0, op_r.n});
  assign out_free  = !out_valid_r || out_ch.ready;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_acc
      assign acc_c[g] = acc_rd_r[g*AWD +: AWD];
    end
  endgenerate

  // shared multiplier for the cross product
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin mul_a = e1_r[1]; mul_b = e2_r[2]; end
      3'd1:    begin mul_a = e1_r[2]; mul_b = e2_r[1]; end
      3'd2:    begin mul_a = e1_r[2]; mul_b = e2_r[0]; end
      3'd3:    begin mul_a = e1_r[0]; mul_b = e2_r[2]; end
      3'd4:    begin mul_a = e1_r[0]; mul_b = e2_r[1]; end
      3'd5:    begin mul_a = e1_r[1]; mul_b = e2_r[0]; end
      default: begin mul_a = '0;      mul_b = '0;      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign sq     = m_r[cnt_r[1:0]][29:0] * m_r[cnt_r[1:0]][29:0];
  assign rt_try = rt_r + bit_r;
  assign dk     = 4'(5'd16 - cnt_r);
  assign dsh    = {15'b0, rt_r[31:0], 1'b0} << dk;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vna_pkg::B_CLEAR: if (clr_last) state_nxt = emit_r ? vna_pkg::B_DONE : vna_pkg::B_IDLE;
      vna_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_op.kind)
            vna_pkg::OP_CLEAR:  state_nxt = vna_pkg::B_CLEAR;
            vna_pkg::OP_ADD:    state_nxt = vna_pkg::B_PRD;
            vna_pkg::OP_FINISH: state_nxt = (seen_r || q_op.n < CNT_W'(3)) ? vna_pkg::B_DONE
                                                                           : vna_pkg::B_PRD;
            vna_pkg::OP_READ:   state_nxt = vna_pkg::B_RRD;
            default:            state_nxt = vna_pkg::B_DONE;
          endcase
        end
      end
      vna_pkg::B_PRD:   if (cnt_r == 5'd3) state_nxt = vna_pkg::B_EDGE;
      vna_pkg::B_EDGE:  state_nxt = vna_pkg::B_MUL;
      vna_pkg::B_MUL:   if (cnt_r == 5'd5) state_nxt = vna_pkg::B_ARD;
      vna_pkg::B_ARD:   state_nxt = vna_pkg::B_AWR;
      vna_pkg::B_AWR: begin
        if (comp_r == 2'd2) state_nxt = walk_more ? vna_pkg::B_PRD : vna_pkg::B_DONE;
        else                state_nxt = vna_pkg::B_ARD;
      end
      vna_pkg::B_RRD:   state_nxt = vna_pkg::B_RMAG;
      vna_pkg::B_RMAG:  state_nxt = acc_zero ? vna_pkg::B_DONE : vna_pkg::B_RSH;
      vna_pkg::B_RSH:   if (!big) state_nxt = vna_pkg::B_RSQ;
      vna_pkg::B_RSQ:   if (cnt_r == 5'd2) state_nxt = vna_pkg::B_RSQRT;
      vna_pkg::B_RSQRT: if (cnt_r == 5'd30) state_nxt = vna_pkg::B_RDIV;
      vna_pkg::B_RDIV:  if (cnt_r == 5'd16 && comp_r == 2'd2) state_nxt = vna_pkg::B_DONE;
      vna_pkg::B_DONE:  if (out_free) state_nxt = vna_pkg::B_IDLE;
      default:          state_nxt = vna_pkg::B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_nxt    = op_r;
    clr_nxt   = clr_r;
    emit_nxt  = emit_r;
    seen_nxt  = seen_r;
    walk_nxt  = walk_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    p_nxt     = p_r;
    e1_nxt    = e1_r;
    e2_nxt    = e2_r;
    cr_nxt    = cr_r;
    m_nxt     = m_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;
    rt_nxt    = rt_r;
    bit_nxt   = bit_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    q_pop     = 1'b0;
    pos_we    = 1'b0;
    pos_waddr = ADDR_W'(q_op.a);
    pos_wdata = q_op.pos;
    pos_raddr = crn[cnt_r[1:0] == 2'd3 ? 2'd2 : cnt_r[1:0]];
    acc_we    = 1'b0;
    acc_waddr = crn[comp_r == 2'd3 ? 2'd2 : comp_r];
    acc_wdata = '0;
    acc_raddr = crn[comp_r == 2'd3 ? 2'd2 : comp_r];
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_n_nxt      = out_n_r;

    case (state_r)
      vna_pkg::B_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_r;
        acc_wdata = '0;
        clr_nxt   = clr_last ? '0 : clr_r + 1'b1;
      end
      vna_pkg::B_IDLE: begin
        q_pop    = q_valid;
        op_nxt   = q_op;
        cnt_nxt  = '0;
        comp_nxt = '0;
        walk_nxt = '0;
        if (q_valid) begin
          case (q_op.kind)
            vna_pkg::OP_CLEAR: begin
              emit_nxt = 1'b1;
              clr_nxt  = '0;
              seen_nxt = 1'b0;
            end
            vna_pkg::OP_LOAD: pos_we = 1'b1;
            vna_pkg::OP_ADD:  seen_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      vna_pkg::B_PRD: begin
        // read corners in turn, data lands in the next cycle
        if (cnt_r != 5'd0) p_nxt[cnt_r[1:0] - 2'd1] = pos_rd_r;
        cnt_nxt = (cnt_r == 5'd3) ? 5'd0 : cnt_r + 1'b1;
      end
      vna_pkg::B_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_nxt[k] = sx(p_r[1][16*k +: 16]) - sx(p_r[0][16*k +: 16]);
          e2_nxt[k] = sx(p_r[2][16*k +: 16]) - sx(p_r[0][16*k +: 16]);
        end
        cnt_nxt = '0;
      end
      vna_pkg::B_MUL: begin
        if (!cnt_r[0]) cr_nxt[cnt_r[2:1]] = 35'(prod);
        else           cr_nxt[cnt_r[2:1]] = cr_r[cnt_r[2:1]] - 35'(prod);
        cnt_nxt  = (cnt_r == 5'd5) ? 5'd0 : cnt_r + 1'b1;
        comp_nxt = '0;
      end
      vna_pkg::B_ARD: ;
      vna_pkg::B_AWR: begin
        acc_we    = 1'b1;
        acc_wdata = {sat_add(acc_c[2], cr_r[2]), sat_add(acc_c[1], cr_r[1]),
                     sat_add(acc_c[0], cr_r[0])};
        if (comp_r == 2'd2) begin
          comp_nxt = '0;
          cnt_nxt  = '0;
          walk_nxt = walk_r + CNT_W'(3);
        end else begin
          comp_nxt = comp_r + 1'b1;
        end
      end
      vna_pkg::B_RRD: acc_raddr = ADDR_W'(op_r.a);
      vna_pkg::B_RMAG: begin
        for (int k = 0; k < 3; k++) begin
          neg_nxt[k] = acc_c[k][AWD-1];
          m_nxt[k]   = acc_c[k][AWD-1] ? (~acc_c[k] + 1'b1) : acc_c[k];
        end
        if (acc_zero) begin
          q_nxt[0] = '0;
          q_nxt[1] = 16'd16384;
          q_nxt[2] = '0;
          neg_nxt  = '0;
        end
        cnt_nxt = '0;
      end
      vna_pkg::B_RSH: begin
        if (big) begin
          for (int k = 0; k < 3; k++) m_nxt[k] = m_r[k] >> 1;
        end
        cnt_nxt = '0;
      end
      vna_pkg::B_RSQ: begin
        rem_nxt = (cnt_r == 5'd0 ? 62'd0 : rem_r) + 62'(sq);
        if (cnt_r == 5'd2) begin
          cnt_nxt = '0;
          rt_nxt  = '0;
          bit_nxt = 62'd1 << 60;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      vna_pkg::B_RSQRT: begin
        // one result bit per cycle, restoring
        if (rem_r >= rt_try) begin
          rem_nxt = rem_r - rt_try;
          rt_nxt  = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        cnt_nxt  = (cnt_r == 5'd30) ? 5'd0 : cnt_r + 1'b1;
        comp_nxt = '0;
      end
      vna_pkg::B_RDIV: begin
        // (m*32768 + len) / (2*len), one quotient bit per cycle
        if (cnt_r == 5'd0) begin
          dv_nxt         = {m_r[comp_r][29:0], 15'b0} + 46'(rt_r[31:0]);
          q_nxt[comp_r]  = '0;
        end else if ({2'b0, dv_r} >= dsh) begin
          dv_nxt            = dv_r - dsh[45:0];
          q_nxt[comp_r][dk] = 1'b1;
        end
        if (cnt_r == 5'd16) begin
          cnt_nxt  = '0;
          comp_nxt = comp_r + 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      vna_pkg::B_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          emit_nxt       = 1'b0;
          out_status_nxt = (op_r.kind == vna_pkg::OP_REPORT) ? op_r.status : vna_pkg::ST_OK;
          for (int k = 0; k < 3; k++) begin
            if (op_r.kind == vna_pkg::OP_READ) out_n_nxt[k] = neg_r[k] ? -q_r[k] : q_r[k];
            else                               out_n_nxt[k] = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vna_pkg::B_CLEAR;
      clr_r       <= '0;
      emit_r      <= 1'b0;
      seen_r      <= 1'b0;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      emit_r      <= emit_nxt;
      seen_r      <= seen_nxt;
      cnt_r       <= cnt_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    walk_r       <= walk_nxt;
    p_r          <= p_nxt;
    e1_r         <= e1_nxt;
    e2_r         <= e2_nxt;
    cr_r         <= cr_nxt;
    m_r          <= m_nxt;
    neg_r        <= neg_nxt;
    rem_r        <= rem_nxt;
    rt_r         <= rt_nxt;
    bit_r        <= bit_nxt;
    dv_r         <= dv_nxt;
    q_r          <= q_nxt;
    out_status_r <= out_status_nxt;
    out_n_r      <= out_n_nxt;
  end

  assign bstat.clearing  = (state_r == vna_pkg::B_CLEAR);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.normal_x = out_n_r[0];
  assign out_ch.normal_y = out_n_r[1];
  assign out_ch.normal_z = out_n_r[2];

endmodule

// ===== rtl/core/vna_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module vna_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(normal_x)
      && $stable(normal_y) && $stable(normal_z))
    else $error("result word changed while stalled");

  // no result word right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // error words carry zero normals
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != vna_pkg::ST_OK |->
      normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0)
    else $error("nonzero normal on error status");

  // unit normal components stay within Q1.14 one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
      && normal_y >= -16'sd16384 && normal_y <= 16'sd16384
      && normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
    else $error("normal component out of range");

  // status is one of the three codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == vna_pkg::ST_OK || status == vna_pkg::ST_RANGE
      || status == vna_pkg::ST_EMPTY)
    else $error("bad status code");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .normal_x  (out_ch.normal_x),
  .normal_y  (out_ch.normal_y),
  .normal_z  (out_ch.normal_z)
);

// ===== tb/vertex_normal_accumulator_test.sv =====
// Self-checking testbench for the vertex normal accumulator.
`timescale 1ns / 1ps

module vertex_normal_accumulator_test;
  import vna_pkg::*;

  localparam int DEPTH = 1024;
  localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } result_t;

  // one directed row: either a register write or a command word
  typedef struct {
    bit                      is_cfg;
    logic [CNT_W-1:0]        count;
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        a, b, c;
    logic signed [POS_W-1:0] x, y, z;
    bit                      typed;
    result_t                 res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  vna_in_if  in_ch();
  vna_out_if out_ch();

  vertex_normal_accumulator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow of the block's state
  logic signed [POS_W-1:0] vpos[DEPTH][3];
  bit                      loaded[DEPTH];
  longint                  accum[DEPTH][3];
  bit                      tri_seen;
  int unsigned             vcount;

  result_t pending_results[$];
  int      mismatches = 0;
  bit      calm = 1'b0;   // no idling on either side while set

  function automatic int unsigned live_count();
    return (vcount < DEPTH) ? vcount : DEPTH;
  endfunction

  function automatic longint sat_add(longint acc, longint f);
    if (f > 0 && acc > ACC_HI - f) return ACC_HI;
    if (f < 0 && acc < ACC_LO - f) return ACC_LO;
    return acc + f;
  endfunction

  function automatic void add_face(int i0, int i1, int i2);
    longint e1[3], e2[3], cr[3];
    for (int k = 0; k < 3; k++) begin
      e1[k] = longint'(vpos[i1][k]) - longint'(vpos[i0][k]);
      e2[k] = longint'(vpos[i2][k]) - longint'(vpos[i0][k]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int k = 0; k < 3; k++) begin
      accum[i0][k] = sat_add(accum[i0][k], cr[k]);
      accum[i1][k] = sat_add(accum[i1][k], cr[k]);
      accum[i2][k] = sat_add(accum[i2][k], cr[k]);
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic result_t unit_normal(int idx);
    result_t res;
    longint unsigned m[3], mx, len, q;
    logic [15:0] comp[3];
    res = '0;
    for (int k = 0; k < 3; k++)
      m[k] = (accum[idx][k] < 0) ? longint'(-accum[idx][k]) : accum[idx][k];
    if (m[0] == 0 && m[1] == 0 && m[2] == 0) begin
      res.ny = 16'sd16384;
      return res;
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    // scale down until every magnitude fits below 2^30
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) m[k] >>= 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int k = 0; k < 3; k++) begin
      q = (m[k] * 32768 + len) / (2 * len);
      if (accum[idx][k] < 0) q = -q;
      comp[k] = q[15:0];
    end
    res.nx = comp[0];
    res.ny = comp[1];
    res.nz = comp[2];
    return res;
  endfunction

  // advance the shadow state by one accepted word, return its result
  function automatic result_t apply_word(logic [CMD_W-1:0] cmd, int ia, int ib, int ic,
                                         logic signed [POS_W-1:0] px, py, pz);
    result_t     res;
    int unsigned n;
    res = '0;
    n = live_count();
    case (cmd)
      CMD_RESTART: begin
        for (int i = 0; i < DEPTH; i++)
          for (int k = 0; k < 3; k++) accum[i][k] = 0;
        tri_seen = 1'b0;
      end
      CMD_LOAD: begin
        if (ia >= n) res.status = ST_RANGE;
        else begin
          vpos[ia][0] = px;
          vpos[ia][1] = py;
          vpos[ia][2] = pz;
          loaded[ia] = 1'b1;
        end
      end
      CMD_ADD: begin
        if (ia >= n || ib >= n || ic >= n) res.status = ST_RANGE;
        else begin
          add_face(ia, ib, ic);
          tri_seen = 1'b1;
        end
      end
      CMD_FINISH: begin
        if (n == 0) res.status = ST_EMPTY;
        else if (!tri_seen)
          for (int i = 0; i + 2 < n; i += 3) add_face(i, i + 1, i + 2);
      end
      CMD_READ: begin
        if (ia >= n) res.status = ST_RANGE;
        else res = unit_normal(ia);
      end
      default: ;
    endcase
    return res;
  endfunction

  // finish may only run when every position it walks has been loaded
  function automatic bit finish_safe();
    int unsigned n;
    n = live_count();
    if (n == 0 || tri_seen) return 1'b1;
    for (int i = 0; i < n - n % 3; i++)
      if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Drive one word at negedge, hold until taken. A typed result overrides
  // the predicted one, though the predictor still updates its state.
  task automatic send_word(logic [CMD_W-1:0] cmd, int ia, int ib, int ic,
                           logic signed [POS_W-1:0] px, py, pz,
                           bit typed, result_t typed_res);
    result_t res;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.index_a <= ia[IDX_W-1:0];
    in_ch.index_b <= ib[IDX_W-1:0];
    in_ch.index_c <= ic[IDX_W-1:0];
    in_ch.pos_x   <= px;
    in_ch.pos_y   <= py;
    in_ch.pos_z   <= pz;
    do @(posedge clk); while (!in_ch.ready);
    res = apply_word(cmd, ia, ib, ic, px, py, pz);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // register write only once the block has gone quiet
  task automatic write_count(int unsigned value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain();
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    vcount = value;
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos();
    logic signed [POS_W-1:0] corner[4];
    corner = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
    case ($urandom_range(3))
      0: return corner[$urandom_range(3)];
      1: return $urandom_range(511) - 256;
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  // in range most of the time, anywhere in the field otherwise
  function automatic int rand_index();
    int unsigned n;
    n = live_count();
    if (n != 0 && $urandom_range(99) < 90) return $urandom_range(n - 1);
    return $urandom_range(DEPTH - 1);
  endfunction

  task automatic random_word();
    int      r, ia, ib, ic;
    result_t none;
    none = '0;
    r  = $urandom_range(299);
    ia = rand_index();
    ib = rand_index();
    ic = rand_index();
    if (r < 2) begin
      send_word(CMD_RESTART, ia, ib, ic, rand_pos(), rand_pos(), rand_pos(), 0, none);
    end else if (r < 12) begin
      send_word($urandom_range(7, 5), ia, ib, ic, rand_pos(), rand_pos(), rand_pos(),
                0, none);
    end else if (r < 24 && finish_safe()) begin
      send_word(CMD_FINISH, ia, ib, ic, rand_pos(), rand_pos(), rand_pos(), 0, none);
    end else if (r < 110) begin
      send_word(CMD_LOAD, ia, ib, ic, rand_pos(), rand_pos(), rand_pos(), 0, none);
    end else if (r < 200) begin
      // an in-range corner that was never loaded becomes a load instead
      if (ia < live_count() && ib < live_count() && ic < live_count() &&
          !(loaded[ia] && loaded[ib] && loaded[ic])) begin
        if (loaded[ia]) ia = loaded[ib] ? ic : ib;
        send_word(CMD_LOAD, ia, ib, ic, rand_pos(), rand_pos(), rand_pos(), 0, none);
      end else begin
        send_word(CMD_ADD, ia, ib, ic, rand_pos(), rand_pos(), rand_pos(), 0, none);
      end
    end else begin
      send_word(CMD_READ, ia, ib, ic, rand_pos(), rand_pos(), rand_pos(), 0, none);
    end
  endtask

  // result side: random back-pressure, set at negedge
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 32);
  end

  // result checker, sampled at posedge
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_ch.status);
          mismatches++;
        end
        if (out_ch.normal_x !== want.nx) begin
          $error("normal_x expected %0d got %0d", want.nx, out_ch.normal_x);
          mismatches++;
        end
        if (out_ch.normal_y !== want.ny) begin
          $error("normal_y expected %0d got %0d", want.ny, out_ch.normal_y);
          mismatches++;
        end
        if (out_ch.normal_z !== want.nz) begin
          $error("normal_z expected %0d got %0d", want.nz, out_ch.normal_z);
          mismatches++;
        end
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    row_t        plan[$];
    result_t     up, none;
    int unsigned phase_counts[$];

    up = '0;
    up.ny = 16'sd16384;
    none = '0;

    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_RESTART;
    in_ch.index_a = '0;
    in_ch.index_b = '0;
    in_ch.index_c = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    out_ch.ready = 1'b0;

    for (int i = 0; i < DEPTH; i++) begin
      loaded[i] = 1'b0;
      for (int k = 0; k < 3; k++) begin
        vpos[i][k] = '0;
        accum[i][k] = 0;
      end
    end
    tri_seen = 1'b0;
    vcount = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows; typed results only where obvious
    plan = '{
      // zero vertex count after reset
      '{0, 0, CMD_FINISH, 0, 0, 0, 0, 0, 0, 1, '{ST_EMPTY, 0, 0, 0}},
      '{0, 0, CMD_READ, 0, 0, 0, 0, 0, 0, 1, '{ST_RANGE, 0, 0, 0}},
      '{0, 0, CMD_LOAD, 0, 0, 0, 1, 2, 3, 1, '{ST_RANGE, 0, 0, 0}},
      '{0, 0, 3'd5, 1023, 1023, 1023, -1, -1, -1, 1, '{ST_OK, 0, 0, 0}},
      '{0, 0, 3'd7, 0, 0, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0}},
      '{1, 3, 0, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      // untouched accumulator reads straight up
      '{0, 0, CMD_READ, 0, 0, 0, 0, 0, 0, 1, up},
      '{0, 0, CMD_LOAD, 0, 0, 0, -32768, -32768, -32768, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_LOAD, 1, 0, 0, 32767, -32768, 32767, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_LOAD, 2, 0, 0, 0, 32767, -32768, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_LOAD, 3, 0, 0, 5, 5, 5, 1, '{ST_RANGE, 0, 0, 0}},
      '{0, 0, CMD_ADD, 0, 1, 2, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_ADD, 0, 1, 3, 0, 0, 0, 1, '{ST_RANGE, 0, 0, 0}},
      '{0, 0, CMD_READ, 2, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      // triangle seen: finish is a no-op
      '{0, 0, CMD_FINISH, 0, 0, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0}},
      '{0, 0, CMD_RESTART, 0, 0, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0}},
      '{0, 0, CMD_READ, 0, 0, 0, 0, 0, 0, 1, up},
      // finish twice walks the triple twice
      '{0, 0, CMD_FINISH, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_FINISH, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_READ, 1, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_READ, 1023, 0, 0, 0, 0, 0, 1, '{ST_RANGE, 0, 0, 0}},
      // count beyond depth clamps to 1024
      '{1, 2047, 0, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_LOAD, 1023, 0, 0, 32767, 32767, -32768, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_READ, 1023, 0, 0, 0, 0, 0, 1, up},
      '{0, 0, CMD_ADD, 1023, 0, 1, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{0, 0, CMD_READ, 1023, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}}
    };
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_count(plan[i].count);
      else send_word(plan[i].cmd, plan[i].a, plan[i].b, plan[i].c,
                     plan[i].x, plan[i].y, plan[i].z, plan[i].typed, plan[i].res);
    end

    // random phases: small meshes mostly, extremes in between
    phase_counts = '{6, 1024, 3, 0, 9, 2047, 4, 12, 1, 30, 7, 1023};
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      calm = (p == 4);
      repeat (135) random_word();
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
